// ===== design/fcc_pkg.sv =====
// Shared types, widths and codes for the FAT cluster chain engine.
package fcc_pkg;

  // Field widths fixed by the transaction format.
  localparam int FUNC_W   = 2;
  localparam int CLUS_W   = 28;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int CFG_DW   = 13;

  // Default table size in clusters.
  localparam int MAX_CLUSTERS_DEF = 4096;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

  // Table formats.
  localparam logic [KIND_W-1:0] KIND_12   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_16   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_32   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // Register indexes.
  localparam logic REG_FAT_KIND      = 1'b0;
  localparam logic REG_CLUSTER_COUNT = 1'b1;

  // Special entry values in the 28-bit domain.
  localparam logic [CLUS_W-1:0] CL_FREE    = 28'h0000000;
  localparam logic [CLUS_W-1:0] CL_RESV    = 28'h0000001;
  localparam logic [CLUS_W-1:0] CL_BAD     = 28'hFFFFFF7;
  localparam logic [CLUS_W-1:0] CL_EOC_LOW = 28'hFFFFFF8;
  localparam logic [CLUS_W-1:0] CL_EOC     = 28'hFFFFFFF;

  // Narrow-format special thresholds.
  localparam logic [11:0] FAT12_SPECIAL = 12'hFF7;
  localparam logic [15:0] FAT16_SPECIAL = 16'hFFF7;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
  } cfg_t;

endpackage

// ===== design/fcc_in_if.sv =====
// Request channel interface: operation, cluster and value to write.
interface fcc_in_if;
  import fcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CLUS_W-1:0]   cluster;
  logic [CLUS_W-1:0]   next_value;

  modport source (output valid, output func, output cluster, output next_value, input ready);
  modport sink   (input valid, input func, input cluster, input next_value, output ready);
endinterface

// ===== design/fcc_out_if.sv =====
// Response channel interface: decoded or allocated value and status.
interface fcc_out_if;
  import fcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CLUS_W-1:0]   result_value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== design/fcc_mem.sv =====
// Byte-wide table memory with one write port and one registered read port.
module fcc_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write first in program order; a same-cycle read returns the old byte.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fcc_seq.sv =====
// Sequencer that runs get, set, allocate and free as byte accesses to the table.
module fcc_seq #(
  parameter int MAX_CLUSTERS = 4096,
  parameter int AW           = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fcc_pkg::cfg_t        cfg_i,
  fcc_in_if.sink               in_if,
  fcc_out_if.source            out_if,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output logic [7:0]           mem_wdata_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  logic [7:0]           mem_rdata_i
);
  import fcc_pkg::*;

  localparam int CW    = $clog2(MAX_CLUSTERS + 1);
  localparam int UW    = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int DEPTH = 4 * MAX_CLUSTERS;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_GET_DONE, S_SET_DONE,
    S_AL_START, S_AL_WALK, S_AL_WALK_CHK, S_AL_S1_INIT, S_AL_S1, S_AL_S1_CHK,
    S_AL_S2, S_AL_S2_CHK, S_AL_FIN_CHK, S_AL_LINK, S_AL_EOC, S_AL_DONE,
    S_FR_START, S_FR_LOOP, S_FR_CLR, S_FR_CHK,
    S_RD_START, S_RD_LOOP, S_WR_START, S_WR_BYTES, S_RESP
  } state_e;

  state_e              state_q, ret_q, wret_q;
  logic [CLUS_W-1:0]   clus_q, here_q, idx_q, wval_q;
  logic [CW-1:0]       cand_q, steps_q;
  logic [AW-1:0]       base_q, clr_q;
  logic [2:0]          rk_q;
  logic [7:0]          raw_q [4];
  logic                oor_q, wok_q;
  logic [CLUS_W-1:0]   res_val_q, out_val_q;
  logic [STATUS_W-1:0] res_st_q, out_st_q;
  logic                out_valid_q;

  logic [UW-1:0]       usable_w;
  logic [CW-1:0]       usable;
  logic [CLUS_W-1:0]   usable28;
  logic [2:0]          nb;
  logic [CW-1:0]       ix;
  logic [AW-1:0]       base;
  logic [15:0]         t16;
  logic [11:0]         t12;
  logic [CLUS_W-1:0]   rd_val;
  logic [7:0]          wbyte;
  logic                kind_bad;

  // Clusters in use, limited to the table size.
  always_comb begin
    usable_w = (UW'(cfg_i.count) > UW'(MAX_CLUSTERS)) ? UW'(MAX_CLUSTERS) : UW'(cfg_i.count);
    usable   = CW'(usable_w);
    usable28 = CLUS_W'(usable);
    kind_bad = (cfg_i.kind == KIND_NONE);
    nb       = (cfg_i.kind == KIND_32) ? 3'd4 : 3'd2;
  end

  // Byte offset of the entry under access.
  always_comb begin
    ix = idx_q[CW-1:0];
    case (cfg_i.kind)
      KIND_12: base = AW'(ix) + AW'(ix >> 1);
      KIND_16: base = AW'(ix) << 1;
      default: base = AW'(ix) << 2;
    endcase
  end

  // Decode the captured bytes into a 28-bit entry value.
  always_comb begin
    t16 = {raw_q[1], raw_q[0]};
    t12 = idx_q[0] ? t16[15:4] : t16[11:0];
    case (cfg_i.kind)
      KIND_12: rd_val = (t12 >= FAT12_SPECIAL) ? {16'hFFFF, t12} : CLUS_W'(t12);
      KIND_16: rd_val = (t16 >= FAT16_SPECIAL) ? {12'hFFF, t16} : CLUS_W'(t16);
      KIND_32: rd_val = {raw_q[3][3:0], raw_q[2], raw_q[1], raw_q[0]};
      default: rd_val = CL_BAD;
    endcase
    if (oor_q) begin
      rd_val = CL_BAD;
    end
  end

  // Byte to store, merging the shared nibbles from the bytes just read.
  always_comb begin
    wbyte = 8'h00;
    case (cfg_i.kind)
      KIND_12: begin
        if (idx_q[0]) begin
          wbyte = (rk_q[0] == 1'b0) ? {wval_q[3:0], raw_q[0][3:0]} : wval_q[11:4];
        end else begin
          wbyte = (rk_q[0] == 1'b0) ? wval_q[7:0] : {raw_q[1][7:4], wval_q[11:8]};
        end
      end
      KIND_16: wbyte = (rk_q[0] == 1'b0) ? wval_q[7:0] : wval_q[15:8];
      default: begin
        case (rk_q[1:0])
          2'd0:    wbyte = wval_q[7:0];
          2'd1:    wbyte = wval_q[15:8];
          2'd2:    wbyte = wval_q[23:16];
          default: wbyte = {raw_q[3][7:4], wval_q[27:24]};
        endcase
      end
    endcase
  end

  // Memory port drive.
  always_comb begin
    mem_raddr_o = base_q + AW'(rk_q);
    mem_we_o    = 1'b0;
    mem_waddr_o = base_q + AW'(rk_q);
    mem_wdata_o = wbyte;
    if (state_q == S_CLEAR) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_q;
      mem_wdata_o = 8'h00;
    end else if (state_q == S_WR_BYTES) begin
      mem_we_o = 1'b1;
    end
  end

  assign in_if.ready         = (state_q == S_IDLE);
  assign out_if.valid        = out_valid_q;
  assign out_if.result_value = out_val_q;
  assign out_if.status       = out_st_q;

  // Control sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      wret_q      <= S_IDLE;
      clus_q      <= '0;
      here_q      <= '0;
      idx_q       <= '0;
      wval_q      <= '0;
      cand_q      <= '0;
      steps_q     <= '0;
      base_q      <= '0;
      clr_q       <= '0;
      rk_q        <= '0;
      raw_q       <= '{default: 8'h00};
      oor_q       <= 1'b0;
      wok_q       <= 1'b0;
      res_val_q   <= '0;
      res_st_q    <= ST_OK;
      out_val_q   <= '0;
      out_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      // The response state reloads the output register itself.
      if (out_valid_q && out_if.ready && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        // Zero the table one byte per cycle.
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_if.valid) begin
            clus_q <= in_if.cluster;
            idx_q  <= in_if.cluster;
            wval_q <= in_if.next_value;
            unique case (in_if.func)
              FUNC_GET: begin
                ret_q   <= S_GET_DONE;
                state_q <= S_RD_START;
              end
              FUNC_SET: begin
                wret_q  <= S_SET_DONE;
                state_q <= S_WR_START;
              end
              FUNC_ALLOC: state_q <= S_AL_START;
              default:    state_q <= S_FR_START;
            endcase
          end
        end
        S_GET_DONE: begin
          res_val_q <= rd_val;
          res_st_q  <= oor_q ? ST_FAIL : ST_OK;
          state_q   <= S_RESP;
        end
        S_SET_DONE: begin
          res_val_q <= '0;
          res_st_q  <= wok_q ? ST_OK : ST_FAIL;
          state_q   <= S_RESP;
        end
        // Allocate: walk to the end of the chain.
        S_AL_START: begin
          steps_q <= '0;
          if (kind_bad || clus_q >= CL_BAD) begin
            res_val_q <= CL_BAD;
            res_st_q  <= ST_FAIL;
            state_q   <= S_RESP;
          end else if (clus_q > CL_RESV) begin
            here_q  <= clus_q;
            state_q <= S_AL_WALK;
          end else begin
            here_q  <= CL_RESV;
            state_q <= S_AL_S1_INIT;
          end
        end
        S_AL_WALK: begin
          if (steps_q >= usable) begin
            res_val_q <= CL_BAD;
            res_st_q  <= ST_LIMIT;
            state_q   <= S_RESP;
          end else begin
            steps_q <= steps_q + CW'(1);
            idx_q   <= here_q;
            ret_q   <= S_AL_WALK_CHK;
            state_q <= S_RD_START;
          end
        end
        S_AL_WALK_CHK: begin
          if (rd_val >= CL_EOC_LOW || rd_val <= CL_RESV) begin
            state_q <= S_AL_S1_INIT;
          end else if (rd_val == CL_BAD) begin
            res_val_q <= CL_BAD;
            res_st_q  <= ST_FAIL;
            state_q   <= S_RESP;
          end else begin
            here_q  <= rd_val;
            state_q <= S_AL_WALK;
          end
        end
        // Search upward from the chain end.
        S_AL_S1_INIT: begin
          cand_q  <= here_q[CW-1:0] + CW'(1);
          state_q <= S_AL_S1;
        end
        S_AL_S1: begin
          if (cand_q < usable) begin
            idx_q   <= CLUS_W'(cand_q);
            ret_q   <= S_AL_S1_CHK;
            state_q <= S_RD_START;
          end else begin
            cand_q  <= CW'(2);
            state_q <= S_AL_S2;
          end
        end
        S_AL_S1_CHK: begin
          if (rd_val == CL_FREE) begin
            state_q <= S_AL_LINK;
          end else begin
            cand_q  <= cand_q + CW'(1);
            state_q <= S_AL_S1;
          end
        end
        // Wrap around below the chain end, then check the last candidate.
        S_AL_S2: begin
          idx_q   <= CLUS_W'(cand_q);
          state_q <= S_RD_START;
          if (CLUS_W'(cand_q) < here_q) begin
            ret_q <= S_AL_S2_CHK;
          end else begin
            ret_q <= S_AL_FIN_CHK;
          end
        end
        S_AL_S2_CHK: begin
          if (rd_val == CL_FREE) begin
            state_q <= S_AL_LINK;
          end else begin
            cand_q  <= cand_q + CW'(1);
            state_q <= S_AL_S2;
          end
        end
        S_AL_FIN_CHK: begin
          if (rd_val == CL_FREE) begin
            state_q <= S_AL_LINK;
          end else begin
            res_val_q <= CL_BAD;
            res_st_q  <= ST_FAIL;
            state_q   <= S_RESP;
          end
        end
        // Link the old end to the new cluster and terminate the chain.
        S_AL_LINK: begin
          if (here_q > CL_RESV) begin
            idx_q   <= here_q;
            wval_q  <= CLUS_W'(cand_q);
            wret_q  <= S_AL_EOC;
            state_q <= S_WR_START;
          end else begin
            state_q <= S_AL_EOC;
          end
        end
        S_AL_EOC: begin
          idx_q   <= CLUS_W'(cand_q);
          wval_q  <= CL_EOC;
          wret_q  <= S_AL_DONE;
          state_q <= S_WR_START;
        end
        S_AL_DONE: begin
          res_val_q <= CLUS_W'(cand_q);
          res_st_q  <= ST_OK;
          state_q   <= S_RESP;
        end
        // Free: read each link, clear it, follow it.
        S_FR_START: begin
          steps_q <= '0;
          here_q  <= clus_q;
          if (kind_bad || clus_q <= CL_RESV || clus_q >= usable28) begin
            res_val_q <= '0;
            res_st_q  <= ST_FAIL;
            state_q   <= S_RESP;
          end else begin
            state_q <= S_FR_LOOP;
          end
        end
        S_FR_LOOP: begin
          if (steps_q >= usable) begin
            res_val_q <= '0;
            res_st_q  <= ST_LIMIT;
            state_q   <= S_RESP;
          end else begin
            steps_q <= steps_q + CW'(1);
            idx_q   <= here_q;
            ret_q   <= S_FR_CLR;
            state_q <= S_RD_START;
          end
        end
        S_FR_CLR: begin
          here_q  <= rd_val;
          wval_q  <= CL_FREE;
          wret_q  <= S_FR_CHK;
          state_q <= S_WR_START;
        end
        S_FR_CHK: begin
          if (here_q >= CL_BAD || here_q <= CL_RESV) begin
            res_val_q <= '0;
            res_st_q  <= ST_OK;
            state_q   <= S_RESP;
          end else begin
            state_q <= S_FR_LOOP;
          end
        end
        // Entry read: range check, then one byte per cycle.
        S_RD_START: begin
          rk_q <= '0;
          if (kind_bad || idx_q >= usable28) begin
            oor_q   <= 1'b1;
            state_q <= ret_q;
          end else begin
            oor_q   <= 1'b0;
            base_q  <= base;
            state_q <= S_RD_LOOP;
          end
        end
        S_RD_LOOP: begin
          if (rk_q != 3'd0) begin
            raw_q[2'(rk_q - 3'd1)] <= mem_rdata_i;
          end
          if (rk_q == nb) begin
            rk_q    <= '0;
            state_q <= ret_q;
          end else begin
            rk_q <= rk_q + 3'd1;
          end
        end
        // Entry write: read the bytes first so shared nibbles survive.
        S_WR_START: begin
          if (kind_bad || idx_q <= CL_RESV || idx_q >= usable28) begin
            wok_q   <= 1'b0;
            state_q <= wret_q;
          end else begin
            wok_q   <= 1'b1;
            ret_q   <= S_WR_BYTES;
            state_q <= S_RD_START;
          end
        end
        S_WR_BYTES: begin
          if (rk_q == nb - 3'd1) begin
            rk_q    <= '0;
            state_q <= wret_q;
          end else begin
            rk_q <= rk_q + 3'd1;
          end
        end
        // Hand the result to the output register once it is free.
        S_RESP: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/fat_cluster_chain_engine_top.sv =====
// Top level: configuration registers, sequencer and table memory.
// One transaction at a time. Each entry read uses the single byte read port, two bytes
// (16-bit, 12-bit) or four bytes (32-bit); a write re-reads the entry, then writes 2 or 4 bytes.
// Allocate and free repeat these accesses per chain step and per scanned candidate;
// the chain walk is bounded by cluster_count steps, limited to MAX_CLUSTERS.
// After reset the table is zeroed one byte per cycle, all 4 * MAX_CLUSTERS bytes
// (16384 by default), with no transaction taken until it completes.
module fat_cluster_chain_engine_top #(
  parameter int MAX_CLUSTERS = fcc_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [fcc_pkg::CFG_DW-1:0]  cfg_data_i,
  fcc_in_if.sink                      in_if,
  fcc_out_if.source                   out_if
);
  import fcc_pkg::*;

  localparam int DEPTH = 4 * MAX_CLUSTERS;
  localparam int AW    = $clog2(DEPTH);

  cfg_t          cfg_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind  <= KIND_32;
      cfg_q.count <= COUNT_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FAT_KIND:      cfg_q.kind  <= cfg_data_i[KIND_W-1:0];
        REG_CLUSTER_COUNT: cfg_q.count <= cfg_data_i[COUNT_W-1:0];
        default:           cfg_q       <= cfg_q;
      endcase
    end
  end

  fcc_seq #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .AW           (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_if       (in_if),
    .out_if      (out_if),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fcc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // One transaction in flight: an accepted request closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request accepted while another is in progress");

  // Status is always one of the three defined codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.status == ST_OK || out_if.status == ST_FAIL ||
                      out_if.status == ST_LIMIT))
    else $error("undefined status code");

  // A walk limit answers either bad (allocate) or zero (free).
  a_limit_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status == ST_LIMIT) |->
      (out_if.result_value == CL_BAD || out_if.result_value == CL_FREE))
    else $error("walk limit with unexpected value");

endmodule

// ===== test/fcc_checker.sv =====
// Checker for the FAT cluster chain engine: table model, prediction and comparison.
`timescale 1ns / 1ps

module fcc_checker
  import fcc_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_DW-1:0]  cfg_data_i,
  fcc_in_if                  in_ch,
  fcc_out_if                 out_ch,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [CLUS_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic [7:0]         fat_bytes [4*MAX_CLUSTERS];
  logic [KIND_W-1:0]  kind_q;
  logic [COUNT_W-1:0] count_q;
  answer_t            answer_q[$];

  // Entries in use, saturated at the table size.
  function automatic int unsigned usable();
    return (count_q > MAX_CLUSTERS) ? MAX_CLUSTERS : count_q;
  endfunction

  // Decodes one entry, widening narrow special values.
  function automatic int unsigned entry_get(int unsigned idx);
    int unsigned off;
    int unsigned t;
    if (idx >= usable()) return CL_BAD;
    case (kind_q)
      KIND_12: begin
        off = (idx * 3) / 2;
        t = fat_bytes[off] | (fat_bytes[off+1] << 8);
        t = idx[0] ? (t >> 4) : (t & 32'h0FFF);
        if (t >= FAT12_SPECIAL) t = 32'h0FFFF000 | t;
        return t;
      end
      KIND_16: begin
        off = idx * 2;
        t = fat_bytes[off] | (fat_bytes[off+1] << 8);
        if (t >= FAT16_SPECIAL) t = 32'h0FFF0000 | t;
        return t;
      end
      KIND_32: begin
        off = idx * 4;
        t = fat_bytes[off] | (fat_bytes[off+1] << 8) | (fat_bytes[off+2] << 16)
          | (fat_bytes[off+3] << 24);
        return t & 32'h0FFFFFFF;
      end
      default: return CL_BAD;
    endcase
  endfunction

  // Packs one entry; returns 0 when the write is refused.
  function automatic bit entry_put(int unsigned idx, int unsigned val);
    int unsigned off;
    int unsigned v;
    if (idx <= CL_RESV || idx >= usable() || kind_q == KIND_NONE) return 0;
    if (kind_q == KIND_12) begin
      off = (idx * 3) / 2;
      v = val & 32'h0FFF;
      if (idx[0]) begin
        fat_bytes[off]   = 8'(((v << 4) & 8'hF0) | (fat_bytes[off] & 8'h0F));
        fat_bytes[off+1] = 8'(v >> 4);
      end else begin
        fat_bytes[off]   = 8'(v & 8'hFF);
        fat_bytes[off+1] = 8'((fat_bytes[off+1] & 8'hF0) | (v >> 8));
      end
    end else if (kind_q == KIND_16) begin
      off = idx * 2;
      fat_bytes[off]   = 8'(val & 8'hFF);
      fat_bytes[off+1] = 8'((val >> 8) & 8'hFF);
    end else begin
      off = idx * 4;
      fat_bytes[off]   = 8'(val & 8'hFF);
      fat_bytes[off+1] = 8'((val >> 8) & 8'hFF);
      fat_bytes[off+2] = 8'((val >> 16) & 8'hFF);
      fat_bytes[off+3] = 8'((fat_bytes[off+3] & 8'hF0) | ((val >> 24) & 8'h0F));
    end
    return 1;
  endfunction

  // Walks to the chain end, finds a free cluster with wraparound and links it.
  function automatic answer_t chain_append(int unsigned head);
    int unsigned cnt;
    int unsigned here;
    int unsigned cand;
    int unsigned nxt;
    int unsigned steps;
    bit          ok;
    answer_t     a;
    cnt = usable();
    here = head;
    steps = 0;
    a.value = CL_BAD;
    a.status = ST_FAIL;
    if (kind_q == KIND_NONE || head >= CL_BAD) return a;
    if (here > CL_RESV) begin
      forever begin
        if (steps >= cnt) begin
          a.status = ST_LIMIT;
          return a;
        end
        steps++;
        nxt = entry_get(here);
        if (nxt >= CL_EOC_LOW || nxt <= CL_RESV) break;
        if (nxt == CL_BAD) return a;
        here = nxt;
      end
    end else begin
      here = CL_RESV;
    end
    for (cand = here + 1; cand < cnt; cand++)
      if (entry_get(cand) == CL_FREE) break;
    if (cand >= cnt)
      for (cand = CL_RESV + 1; cand < here; cand++)
        if (entry_get(cand) == CL_FREE) break;
    if (entry_get(cand) != CL_FREE) return a;
    if (here > CL_RESV) ok = entry_put(here, cand);
    ok = entry_put(cand, CL_EOC);
    a.value = CLUS_W'(cand);
    a.status = ST_OK;
    return a;
  endfunction

  // Clears every entry of a chain.
  function automatic logic [STATUS_W-1:0] chain_release(int unsigned head);
    int unsigned cnt;
    int unsigned here;
    int unsigned nxt;
    int unsigned steps;
    bit          ok;
    cnt = usable();
    here = head;
    steps = 0;
    if (kind_q == KIND_NONE || head <= CL_RESV || head >= cnt) return ST_FAIL;
    forever begin
      if (steps >= cnt) return ST_LIMIT;
      steps++;
      nxt = entry_get(here);
      ok = entry_put(here, CL_FREE);
      if (nxt >= CL_BAD || nxt <= CL_RESV) return ST_OK;
      here = nxt;
    end
  endfunction

  // Predicts the answer of one request and updates the table.
  function automatic answer_t predict_answer(logic [FUNC_W-1:0] func,
                                             int unsigned clus, int unsigned nval);
    answer_t a;
    a.value = CL_FREE;
    a.status = ST_OK;
    case (func)
      FUNC_GET: begin
        if (kind_q == KIND_NONE || clus >= usable()) begin
          a.value = CL_BAD;
          a.status = ST_FAIL;
        end else begin
          a.value = CLUS_W'(entry_get(clus));
        end
      end
      FUNC_SET:   a.status = entry_put(clus, nval) ? ST_OK : ST_FAIL;
      FUNC_ALLOC: a = chain_append(clus);
      default:    a.status = chain_release(clus);
    endcase
    return a;
  endfunction

  assign pending_o = answer_q.size();

  // Track configuration, predict accepted requests, compare accepted responses.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      foreach (fat_bytes[i]) fat_bytes[i] = 8'h00;
      kind_q = KIND_32;
      count_q = 13'd4096;
      answer_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FAT_KIND) kind_q = cfg_data_i[KIND_W-1:0];
        else count_q = cfg_data_i[COUNT_W-1:0];
      end
      if (in_ch.valid && in_ch.ready)
        answer_q.push_back(predict_answer(in_ch.func, in_ch.cluster, in_ch.next_value));
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected response: value %h status %0d",
                     out_ch.result_value, out_ch.status);
        end else begin
          exp_a = answer_q.pop_front();
          if (out_ch.result_value !== exp_a.value || out_ch.status !== exp_a.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected value %h status %0d, got value %h status %0d",
                       exp_a.value, exp_a.status, out_ch.result_value, out_ch.status);
          end
        end
      end
    end
  end

endmodule

// ===== test/fat_cluster_chain_engine_top_tb.sv =====
// Testbench top for the FAT cluster chain engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module fat_cluster_chain_engine_top_tb;
  import fcc_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  int                fail_count;
  int                pending;
  int unsigned       cur_count;
  logic [KIND_W-1:0] cur_kind;
  bit                calm;
  bit                hold_req;
  bit                hold_used;
  int                hold_left;

  fcc_in_if  in_ch();
  fcc_out_if out_ch();

  fat_cluster_chain_engine_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  fcc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Response side: random stalls plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_used = 0;
    end else begin
      if (hold_req && !hold_used) begin
        hold_used = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // Offers one request and waits for its transaction.
  task automatic send_req(logic [FUNC_W-1:0] func, logic [CLUS_W-1:0] clus,
                          logic [CLUS_W-1:0] nval);
    if (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.cluster    <= clus;
    in_ch.next_value <= nval;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drains the engine, then writes both registers.
  task automatic set_config(logic [KIND_W-1:0] kind, int unsigned count);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_FAT_KIND;
    cfg_data_i <= CFG_DW'(kind);
    @(posedge clk_i);
    cfg_idx_i  <= REG_CLUSTER_COUNT;
    cfg_data_i <= CFG_DW'(count);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_kind  = kind;
    cur_count = count;
  endtask

  // Picks an entry value that is often a pointer or a special code of the format.
  function automatic logic [CLUS_W-1:0] pick_value();
    int unsigned r;
    int unsigned lim;
    r = $urandom_range(99);
    lim = (cur_count > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : cur_count;
    if (r < 45) return CLUS_W'($urandom_range(lim + 1, 0));
    if (r < 65) begin
      case (cur_kind)
        KIND_12: return CLUS_W'($urandom_range(12'hFFF, 12'hFF6));
        KIND_16: return CLUS_W'($urandom_range(16'hFFFF, 16'hFFF6));
        default: return CLUS_W'($urandom_range(CL_EOC, CL_BAD - 1));
      endcase
    end
    return CLUS_W'($urandom());
  endfunction

  // Random request mix weighted toward chain building.
  task automatic send_random();
    int unsigned r;
    int unsigned lim;
    logic [FUNC_W-1:0] func;
    logic [CLUS_W-1:0] clus;
    r = $urandom_range(99);
    lim = (cur_count > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : cur_count;
    if (r < 25) func = FUNC_GET;
    else if (r < 50) func = FUNC_SET;
    else if (r < 85) func = FUNC_ALLOC;
    else func = FUNC_FREE;
    r = $urandom_range(99);
    if (r < 80) clus = CLUS_W'($urandom_range(lim + 1, 0));
    else if (r < 90) clus = CLUS_W'($urandom());
    else clus = CLUS_W'($urandom_range(CL_EOC, CL_BAD - 1));
    send_req(func, clus, pick_value());
  endtask

  // Fixed run limit.
  initial begin
    #1_000_000_000;
    $display("fat_cluster_chain_engine_top verification failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [KIND_W-1:0] kinds [12] = '{KIND_12, KIND_16, KIND_32, KIND_NONE, KIND_12, KIND_16,
                                      KIND_32, KIND_12, KIND_16, KIND_32, KIND_32, KIND_12};
    int unsigned counts [12] = '{2, 17, 33, 40, 64, 100, 8191, 4096, 5, 24, 48, 31};
    int unsigned items [12] = '{120, 160, 160, 60, 200, 200, 25, 25, 150, 250, 250, 250};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FAT_KIND;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_GET;
    in_ch.cluster = '0;
    in_ch.next_value = '0;
    calm = 0;
    hold_req = 0;
    cur_kind = KIND_32;
    cur_count = 4096;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset configuration.
    send_req(FUNC_GET, 0, 0);
    send_req(FUNC_GET, 4095, 0);
    send_req(FUNC_GET, 4096, 0);
    send_req(FUNC_GET, 28'hFFFFFFF, 0);
    send_req(FUNC_SET, 1, 5);
    send_req(FUNC_SET, 0, 5);
    send_req(FUNC_SET, 4096, 5);
    send_req(FUNC_SET, 2, 28'hFFFFFFF);
    send_req(FUNC_GET, 2, 0);
    send_req(FUNC_ALLOC, 0, 0);
    send_req(FUNC_ALLOC, 1, 0);
    send_req(FUNC_ALLOC, CL_BAD, 0);
    send_req(FUNC_ALLOC, 2, 0);
    // A chain that runs into a bad entry.
    send_req(FUNC_SET, 5, CL_BAD);
    send_req(FUNC_SET, 4, 5);
    send_req(FUNC_ALLOC, 4, 0);
    // A chain pointing outside the table.
    send_req(FUNC_SET, 8, 28'h0ABCDEF);
    send_req(FUNC_ALLOC, 8, 0);
    // A loop hits the walk limit; free then breaks it.
    send_req(FUNC_SET, 6, 7);
    send_req(FUNC_SET, 7, 6);
    send_req(FUNC_ALLOC, 6, 0);
    send_req(FUNC_FREE, 6, 0);
    send_req(FUNC_FREE, 1, 0);
    send_req(FUNC_FREE, 4096, 0);
    send_req(FUNC_FREE, 2, 0);

    // Random phases over several formats and sizes.
    for (int p = 0; p < 12; p++) begin
      set_config(kinds[p], counts[p]);
      calm = (p == 4);
      if (p == 5) hold_req = 1;
      for (int i = 0; i < items[p]; i++) send_random();
    end
    in_ch.valid <= 1'b0;
    calm = 0;

    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("fat_cluster_chain_engine_top verification clean");
    end else begin
      $display("fat_cluster_chain_engine_top verification failed");
    end
    $finish;
  end

endmodule
